// ----- rtl/phgf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the peak hold meter with gravity fall.
package phgf_pkg;

   localparam int BAR_W     = 6;
   localparam int LEVEL_W   = 16;
   localparam int STEP_W    = 16;
   localparam int GRAV_W    = 16;
   localparam int VEL_W     = 24;
   localparam int COUNT_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // gravity is Q4.12, step Q0.16, velocity Q8.16, level Q2.14
   localparam int GRAV_FRAC  = 12;
   localparam int DROP_SHIFT = 18;

   localparam int DEF_MAX_BARS = 64;

   localparam logic [COUNT_W-1:0] RST_BAR_COUNT = COUNT_W'(64);
   localparam logic [GRAV_W-1:0]  RST_GRAVITY   = GRAV_W'(4915);
   localparam logic [STEP_W-1:0]  RST_MAX_STEP  = STEP_W'(6554);

   localparam logic [CSR_IDX_W-1:0] REG_BAR_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GRAVITY   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_STEP  = CSR_IDX_W'(2);

   typedef enum logic [2:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_LOOKUP,
      STATE_GROW,
      STATE_SCALE,
      STATE_FALL,
      STATE_FINISH
   } phgf_state_type;

endpackage

// ----- rtl/phgf_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module phgf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/peak_hold_gravity_fall.sv -----
`timescale 1ns / 1ps
// Per-bar peak hold with ballistic fall. One item is taken at a time: for a bar that
// is out of use or sees a new peak the result goes LOOKUP then FINISH, for a falling
// bar LOOKUP, GROW, SCALE, FALL, FINISH, set by the single 24x16 multiplier being used
// twice in sequence (gravity * step, then velocity * step) after the store's registered
// read. The result is loaded in FINISH once the output register is free, and the input
// opens again as the state returns to IDLE. Peaks and velocities share one MAX_BARS-deep
// memory; after reset and after every write of bar_count a clearing pass over all
// MAX_BARS entries zeroes it, during which req_stall is high. Results sit in an output
// register, so a new item may be accepted while the previous result waits.
module peak_hold_gravity_fall
   import phgf_pkg::*;
#(
   parameter int MAX_BARS = DEF_MAX_BARS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BAR_W-1:0]     req_bar_index,
   input  logic [LEVEL_W-1:0]   req_level,
   input  logic [STEP_W-1:0]    req_frame_step,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [LEVEL_W-1:0]   rsp_peak_level,
   output logic [BAR_W-1:0]     rsp_peak_bar,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int ADDR_W  = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
   localparam int ENTRY_W = LEVEL_W + VEL_W;
   localparam int PROD_W  = VEL_W + STEP_W;
   localparam int DROP_W  = PROD_W - DROP_SHIFT;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BARS - 1);

   phgf_state_type state_ff, state_in;

   logic [COUNT_W-1:0] bar_count_ff;
   logic [GRAV_W-1:0]  gravity_ff;
   logic [STEP_W-1:0]  max_step_ff;

   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [BAR_W-1:0]   bar_ff, bar_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               in_range_ff, in_range_in;
   logic [LEVEL_W-1:0] peak_ff, peak_in;
   logic [VEL_W-1:0]   vel_ff, vel_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic [BAR_W-1:0]   rsp_bar_ff;

   logic               req_take;
   logic               csr_take;
   logic               count_write;
   logic               slot_free;
   logic               lookup_fall;
   logic [LEVEL_W-1:0] rd_peak;
   logic [VEL_W-1:0]   rd_vel;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [VEL_W:0]     vel_sum;
   logic [DROP_W-1:0]  drop;
   logic [VEL_W-1:0]   mul_a;

   // control from the sequencer
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               mul_en;
   logic               mul_vel;
   logic               rsp_load;

   assign csr_ready   = 1'b1;
   assign csr_take    = csr_valid && csr_ready;
   assign count_write = csr_take && (csr_index == REG_BAR_COUNT);
   assign req_stall   = (state_ff != STATE_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;

   assign rd_peak     = ram_rdata[ENTRY_W-1:VEL_W];
   assign rd_vel      = ram_rdata[VEL_W-1:0];
   assign lookup_fall = in_range_ff && (level_ff < rd_peak);

   phgf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BARS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ADDR_W'(req_bar_index)),
      .rd_data (ram_rdata)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bar_count_ff <= RST_BAR_COUNT;
         gravity_ff   <= RST_GRAVITY;
         max_step_ff  <= RST_MAX_STEP;
      end else if (csr_take) begin
         unique case (csr_index)
            REG_BAR_COUNT: bar_count_ff <= csr_wdata[COUNT_W-1:0];
            REG_GRAVITY:   gravity_ff   <= csr_wdata[GRAV_W-1:0];
            REG_MAX_STEP:  max_step_ff  <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_CLEAR:  if (clr_addr_ff == LAST_ADDR) state_in = STATE_IDLE;
         STATE_IDLE:   if (req_take) state_in = STATE_LOOKUP;
         STATE_LOOKUP: state_in = lookup_fall ? STATE_GROW : STATE_FINISH;
         STATE_GROW:   state_in = STATE_SCALE;
         STATE_SCALE:  state_in = STATE_FALL;
         STATE_FALL:   state_in = STATE_FINISH;
         STATE_FINISH: if (slot_free) state_in = STATE_IDLE;
         default:      state_in = STATE_CLEAR;
      endcase
      if (count_write) begin
         state_in = STATE_CLEAR;
      end
   end

   // sequencer outputs
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(bar_ff);
      ram_wdata = {peak_ff, vel_ff};
      mul_en    = 1'b0;
      mul_vel   = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         STATE_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
         end
         STATE_LOOKUP: mul_en = lookup_fall;
         STATE_SCALE: begin
            mul_en  = 1'b1;
            mul_vel = 1'b1;
         end
         STATE_FINISH: begin
            rsp_load = slot_free;
            ram_we   = slot_free && in_range_ff;
         end
         default: ;
      endcase
   end

   // datapath
   assign mul_a   = mul_vel ? vel_ff : VEL_W'(gravity_ff);
   assign prod_in = mul_en ? PROD_W'(mul_a) * PROD_W'(step_ff) : prod_ff;
   assign vel_sum = {1'b0, vel_ff}
                  + (VEL_W + 1)'(prod_ff[GRAV_W+STEP_W-1:GRAV_FRAC]);
   assign drop    = prod_ff[PROD_W-1:DROP_SHIFT];

   always_comb begin
      bar_in      = bar_ff;
      level_in    = level_ff;
      step_in     = step_ff;
      in_range_in = in_range_ff;
      peak_in     = peak_ff;
      vel_in      = vel_ff;
      if (req_take) begin
         bar_in      = req_bar_index;
         level_in    = req_level;
         step_in     = (req_frame_step > max_step_ff) ? max_step_ff : req_frame_step;
         in_range_in = (COUNT_W'(req_bar_index) < bar_count_ff)
                    && (32'(req_bar_index) < 32'(MAX_BARS));
      end
      unique case (state_ff)
         STATE_LOOKUP: begin
            if (!in_range_ff) begin
               peak_in = '0;
            end else if (!lookup_fall) begin
               peak_in = level_ff;
               vel_in  = '0;
            end else begin
               peak_in = rd_peak;
               vel_in  = rd_vel;
            end
         end
         STATE_GROW: vel_in = vel_sum[VEL_W] ? '1 : vel_sum[VEL_W-1:0];
         STATE_FALL: begin
            if (drop >= DROP_W'(peak_ff)) begin
               peak_in = '0;
            end else begin
               peak_in = peak_ff - drop[LEVEL_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (count_write) begin
         clr_addr_in = '0;
      end else if (state_ff == STATE_CLEAR) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bar_ff      <= bar_in;
      level_ff    <= level_in;
      step_ff     <= step_in;
      in_range_ff <= in_range_in;
      peak_ff     <= peak_in;
      vel_ff      <= vel_in;
      prod_ff     <= prod_in;
      if (rsp_load) begin
         rsp_level_ff <= peak_ff;
         rsp_bar_ff   <= bar_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_peak_level = rsp_level_ff;
   assign rsp_peak_bar   = rsp_bar_ff;

endmodule

// ----- rtl/phgf_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the peak hold meter, bound to the top level.
module phgf_checker
   import phgf_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [LEVEL_W-1:0]   rsp_peak_level,
   input logic [BAR_W-1:0]     rsp_peak_bar,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index
);

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] pending_ff, pending_in;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // items accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff + 2'(req_beat) - 2'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> (pending_ff != 2'd0))
      else $error("result beat with no item outstanding");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("input not stalled while an item is in work");

   a_clear_after_count: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == REG_BAR_COUNT) |=> req_stall)
      else $error("input taken during store clear after bar count write");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("input taken during store clear after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_peak_level) && $stable(rsp_peak_bar)))
      else $error("stalled result beat changed");

endmodule

bind peak_hold_gravity_fall phgf_checker u_phgf_checker (.*);

// ----- bench/peak_hold_gravity_fall_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the peak hold meter: directed corners, then random frames per setting.
module peak_hold_gravity_fall_tb;
   import phgf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = CSR_IDX_W'(3);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 130;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [BAR_W-1:0]   bar;
   } peak_beat_type;

   // Tracks held peaks and fall speeds per bar, queues the peak each beat should return.
   class peak_ledger;
      logic [LEVEL_W-1:0] peaks  [DEF_MAX_BARS];
      logic [VEL_W-1:0]   speeds [DEF_MAX_BARS];
      logic [COUNT_W-1:0] bar_count;
      logic [GRAV_W-1:0]  gravity;
      logic [STEP_W-1:0]  max_step;
      peak_beat_type      pending [$];
      int                 errors;

      function new();
         errors    = 0;
         bar_count = RST_BAR_COUNT;
         gravity   = RST_GRAVITY;
         max_step  = RST_MAX_STEP;
         wipe();
      endfunction

      function void wipe();
         foreach (peaks[i]) begin
            peaks[i]  = '0;
            speeds[i] = '0;
         end
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            REG_BAR_COUNT: begin
               bar_count = data[COUNT_W-1:0];
               wipe();
            end
            REG_GRAVITY:  gravity  = data[GRAV_W-1:0];
            REG_MAX_STEP: max_step = data[STEP_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_level(logic [BAR_W-1:0] bar, logic [LEVEL_W-1:0] level,
                               logic [STEP_W-1:0] frame_step);
         logic [STEP_W-1:0] step;
         int                in_use;
         logic [47:0]       speed;
         logic [47:0]       drop;
         peak_beat_type     beat;
         step       = (frame_step > max_step) ? max_step : frame_step;
         in_use     = (bar_count < DEF_MAX_BARS) ? int'(bar_count) : DEF_MAX_BARS;
         beat.bar   = bar;
         beat.level = '0;
         if (bar < in_use) begin
            if (level >= peaks[bar]) begin
               peaks[bar]  = level;
               speeds[bar] = '0;
            end else begin
               speed = 48'(speeds[bar]) + ((48'(gravity) * 48'(step)) >> GRAV_FRAC);
               if (speed > 48'({VEL_W{1'b1}}))
                  speed = 48'({VEL_W{1'b1}});
               speeds[bar] = speed[VEL_W-1:0];
               drop = (speed * 48'(step)) >> DROP_SHIFT;
               peaks[bar] = (drop >= 48'(peaks[bar])) ? '0 : peaks[bar] - drop[LEVEL_W-1:0];
            end
            beat.level = peaks[bar];
         end
         pending = {pending, beat};
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10)
            $display("mismatch at %0t: %s", $time, msg);
      endfunction

      function void match_peak(logic [LEVEL_W-1:0] level, logic [BAR_W-1:0] bar);
         peak_beat_type want;
         if (pending.size() == 0) begin
            note_error($sformatf("unexpected beat bar %0d level 0x%04h", bar, level));
            return;
         end
         want = pending.pop_front();
         if (want.level !== level || want.bar !== bar)
            note_error($sformatf("bar exp %0d got %0d, level exp 0x%04h got 0x%04h",
                                 want.bar, bar, want.level, level));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [BAR_W-1:0]     req_bar_index;
   logic [LEVEL_W-1:0]   req_level;
   logic [STEP_W-1:0]    req_frame_step;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [LEVEL_W-1:0]   rsp_peak_level;
   logic [BAR_W-1:0]     rsp_peak_bar;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   peak_ledger ledger = new();
   bit         calm;
   int         idle_cycles;

   peak_hold_gravity_fall dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Everything is sampled here, on pre-edge values, so the model sees beats in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            ledger.set_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            ledger.take_level(req_bar_index, req_level, req_frame_step);
         if (rsp_valid && !rsp_stall)
            ledger.match_peak(rsp_peak_level, rsp_peak_bar);
         if ((csr_valid && csr_ready) || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Result side back-pressure: a fresh random hold-off before every beat, none while calm.
   initial begin
      int gap;
      rsp_stall = 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_level(logic [BAR_W-1:0] bar, logic [LEVEL_W-1:0] level,
                             logic [STEP_W-1:0] step);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_bar_index  <= bar;
      req_level      <= level;
      req_frame_step <= step;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Valid drops for one cycle after each write.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending and let every outstanding peak come back. The first edge lets the
   // last accepted beat reach the ledger before the queue is looked at.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending.size() != 0)
         @(posedge clock);
   endtask

   // Mostly a few hot bars with low levels so peaks actually fall; some noise on top.
   task automatic random_frames(int count);
      int                 in_use;
      int                 pick;
      logic [BAR_W-1:0]   bar;
      logic [LEVEL_W-1:0] level;
      logic [STEP_W-1:0]  step;
      in_use = (ledger.bar_count < DEF_MAX_BARS) ? int'(ledger.bar_count) : DEF_MAX_BARS;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (in_use == 0 || pick < 12)
            bar = BAR_W'($urandom_range(0, 63));
         else if (pick < 60)
            bar = BAR_W'($urandom_range(0, ((in_use < 4) ? in_use : 4) - 1));
         else
            bar = BAR_W'($urandom_range(0, in_use - 1));
         pick = $urandom_range(0, 99);
         if (pick < 20)
            level = LEVEL_W'($urandom);
         else if (pick < 35)
            level = LEVEL_W'($urandom_range(49152, 65535));
         else if (pick < 90)
            level = LEVEL_W'($urandom_range(0, 1023));
         else
            level = '0;
         pick = $urandom_range(0, 99);
         if (pick < 10)
            step = '0;
         else if (pick < 40)
            step = STEP_W'($urandom_range(0, 2047));
         else if (pick < 85)
            step = STEP_W'($urandom);
         else
            step = '1;
         send_level(bar, level, step);
      end
   endtask

   initial begin
      reset          = 1'b1;
      calm           = 1'b0;
      idle_cycles    = 0;
      req_valid      = 1'b0;
      req_bar_index  = '0;
      req_level      = '0;
      req_frame_step = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: new peak, clamped fall, zero step, equal level, repeated fall on the last bar
      send_level(6'd0, 16'hFFFF, 16'h0000);
      send_level(6'd0, 16'h0000, 16'hFFFF);
      send_level(6'd0, 16'h0000, 16'h0000);
      send_level(6'd1, 16'h1234, 16'h0100);
      send_level(6'd1, 16'h1234, 16'h0100);
      send_level(6'd63, 16'h8000, 16'h0001);
      repeat (4) send_level(6'd63, 16'h0000, 16'hFFFF);
      settle();
      write_reg(REG_GRAVITY, 16'hFFFF);
      write_reg(REG_MAX_STEP, 16'hFFFF);
      send_level(6'd2, 16'hFFFF, 16'h0000);
      repeat (3) send_level(6'd2, 16'h0001, 16'hFFFF);
      send_level(6'd2, 16'h0000, 16'hFFFF);
      settle();
      write_reg(REG_GRAVITY, 16'h0000);
      send_level(6'd3, 16'h4000, 16'h0000);
      send_level(6'd3, 16'h0000, 16'hFFFF);
      settle();
      write_reg(REG_MAX_STEP, 16'h0000);
      send_level(6'd3, 16'h0000, 16'hFFFF);
      settle();
      // bars past the count come back as zero
      write_reg(REG_BAR_COUNT, 16'd10);
      send_level(6'd9, 16'h7FFF, 16'h0000);
      send_level(6'd10, 16'hFFFF, 16'h0005);
      send_level(6'd63, 16'hFFFF, 16'h0005);
      settle();
      write_reg(REG_BAR_COUNT, 16'd0);
      send_level(6'd0, 16'hFFFF, 16'h0000);
      settle();
      write_reg(REG_BAR_COUNT, 16'd127);
      send_level(6'd63, 16'hAAAA, 16'h0000);
      send_level(6'd63, 16'h5555, 16'hFFFF);
      settle();
      write_reg(REG_SPARE, 16'hFFFF);
      send_level(6'd0, 16'h1111, 16'h0000);

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         calm = (ph == 4);
         case (ph)
            0: begin
               write_reg(REG_BAR_COUNT, 16'(RST_BAR_COUNT));
               write_reg(REG_GRAVITY, RST_GRAVITY);
               write_reg(REG_MAX_STEP, RST_MAX_STEP);
            end
            1: begin
               write_reg(REG_BAR_COUNT, 16'd1);
               write_reg(REG_GRAVITY, 16'hFFFF);
               write_reg(REG_MAX_STEP, 16'hFFFF);
            end
            2: begin
               write_reg(REG_BAR_COUNT, 16'd127);
               write_reg(REG_GRAVITY, 16'($urandom));
               write_reg(REG_MAX_STEP, 16'h0000);
            end
            3: write_reg(REG_BAR_COUNT, 16'd0);
            default: begin
               write_reg(REG_BAR_COUNT, 16'($urandom_range(1, 64)));
               write_reg(REG_GRAVITY, 16'($urandom));
               write_reg(REG_MAX_STEP, 16'($urandom_range(0, 16383)));
            end
         endcase
         if (ph == 5) begin
            // sender holds off mid-stream until the block has drained
            random_frames(PHASE_ITEMS / 2);
            settle();
            random_frames(PHASE_ITEMS / 2);
         end else begin
            random_frames(PHASE_ITEMS);
         end
      end
      calm = 1'b0;

      settle();
      repeat (20) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
